[sv/mrfc_pkg.sv]
// shared types, constants and the crc byte update for the modbus rtu frame checker
package mrfc_pkg;

  localparam int BYTE_W    = 8;
  localparam int CRC_W     = 16;
  localparam int LEN_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [BYTE_W-1:0] ADDR_RESET     = 8'd1;
  localparam logic [BYTE_W-1:0] REG_CODE_RESET = 8'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULE_ADDRESS = 1'b0,
    CFG_BROADCAST_CODE = 1'b1
  } cfg_index_t;

  // frame verdict codes
  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_TOO_SHORT = 2'd1,
    VERDICT_FOREIGN   = 2'd2,
    VERDICT_CRC_BAD   = 2'd3
  } verdict_t;

  // one byte through the reflected crc-16, lsb first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[sv/mrfc_channels_if.sv]
// valid/ready channels for received bytes and frame verdicts
interface mrfc_byte_if;
  import mrfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface mrfc_result_if;
  import mrfc_pkg::*;
  logic             valid;
  logic             ready;
  logic             frame_ok;
  logic [1:0]       verdict;
  logic             is_registration;
  logic [LEN_W-1:0] frame_length;

  modport source (output valid, output frame_ok, output verdict, output is_registration,
                  output frame_length, input ready);
  modport sink   (input valid, input frame_ok, input verdict, input is_registration,
                  input frame_length, output ready);
endinterface

[sv/modbus_rtu_frame_checker_top.sv]
// modbus rtu frame checker: per-frame address and crc-16 verdict from a byte stream
//
// bytes of a received frame arrive one per transfer on byte_ch, with end_of_frame set
// on the last one. each frame yields exactly one verdict transfer on result_ch: ok,
// too short (fewer than two bytes), foreign (first byte is neither module_address nor
// the broadcast code) or crc mismatch (last two bytes, low byte first, differ from the
// modbus crc-16 of all earlier bytes, init 0xffff, reflected poly 0xa001). each byte
// is held first in the input register and then passes through the bytewise crc
// update into the frame state and the result register, in that order. one byte is
// accepted every cycle; only an end-of-frame byte waits, and only while the result
// register still holds a verdict that has not been taken. the crc covers each byte
// two bytes after it arrives, so the two newest bytes always stay held as the
// candidate check value. the length count saturates at MAX_FRAME and is reported in
// nine bits. configuration writes take effect at the next edge and are meant to be
// made while no frame is in flight.
module modbus_rtu_frame_checker_top #(
  parameter int MAX_FRAME = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [mrfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mrfc_pkg::BYTE_W-1:0]    cfg_write_data,
  mrfc_byte_if.sink                     byte_ch,
  mrfc_result_if.source                 result_ch
);
  import mrfc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  // configuration registers
  logic [BYTE_W-1:0] module_address;
  logic [BYTE_W-1:0] broadcast_code;

  // input register
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_eof;

  // frame state
  logic [CRC_W-1:0]  crc;
  logic [BYTE_W-1:0] older_byte;
  logic [BYTE_W-1:0] newer_byte;
  logic [CNT_W-1:0]  byte_count;
  logic [BYTE_W-1:0] lead_byte;

  logic [CRC_W-1:0]  crc_next;
  logic [BYTE_W-1:0] lead_byte_next;
  logic [CNT_W-1:0]  byte_count_next;

  // result register
  logic             res_valid;
  logic             res_ok;
  verdict_t         res_verdict;
  logic             res_reg;
  logic [LEN_W-1:0] res_len;

  verdict_t         verdict_next;
  logic             reg_next;
  logic [LEN_W-1:0] len_next;
  logic [CNT_W+LEN_W-1:0] len_ext;

  logic out_free;
  logic s1_advance;

  // an end-of-frame byte needs a free result slot, other bytes never wait
  assign out_free   = !res_valid || result_ch.ready;
  assign s1_advance = s1_valid && (!s1_eof || out_free);
  assign byte_ch.ready = !s1_valid || s1_advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      module_address <= ADDR_RESET;
      broadcast_code <= REG_CODE_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MODULE_ADDRESS: module_address <= cfg_write_data;
        CFG_BROADCAST_CODE: broadcast_code <= cfg_write_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      s1_valid <= byte_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      s1_byte <= byte_ch.rx_byte;
      s1_eof  <= byte_ch.end_of_frame;
    end
  end

  // per-byte update and verdict
  always_comb begin
    // crc lags the input by two bytes
    crc_next        = (byte_count >= CNT_TWO) ? crc_feed(crc, older_byte) : crc;
    lead_byte_next  = (byte_count == '0) ? s1_byte : lead_byte;
    byte_count_next = (byte_count < CNT_MAX) ? byte_count + CNT_W'(1) : byte_count;
    len_ext         = {{LEN_W{1'b0}}, byte_count_next};
    len_next        = len_ext[LEN_W-1:0];
    reg_next        = 1'b0;
    verdict_next    = VERDICT_OK;
    if (byte_count_next < CNT_TWO) begin
      verdict_next = VERDICT_TOO_SHORT;
    end else begin
      reg_next = (lead_byte_next == broadcast_code);
      if (!reg_next && lead_byte_next != module_address) begin
        verdict_next = VERDICT_FOREIGN;
      end else if ({s1_byte, newer_byte} != crc_next) begin
        verdict_next = VERDICT_CRC_BAD;
      end
    end
  end

  // frame state, cleared after each verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= CRC_INIT;
      older_byte <= '0;
      newer_byte <= '0;
      byte_count <= '0;
      lead_byte  <= '0;
    end else if (s1_advance) begin
      if (s1_eof) begin
        crc        <= CRC_INIT;
        older_byte <= '0;
        newer_byte <= '0;
        byte_count <= '0;
        lead_byte  <= '0;
      end else begin
        crc        <= crc_next;
        older_byte <= newer_byte;
        newer_byte <= s1_byte;
        byte_count <= byte_count_next;
        lead_byte  <= lead_byte_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance && s1_eof) begin
      res_valid <= 1'b1;
    end else if (result_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_eof) begin
      res_ok      <= (verdict_next == VERDICT_OK);
      res_verdict <= verdict_next;
      res_reg     <= reg_next;
      res_len     <= len_next;
    end
  end

  assign result_ch.valid           = res_valid;
  assign result_ch.frame_ok        = res_ok;
  assign result_ch.verdict         = res_verdict;
  assign result_ch.is_registration = res_reg;
  assign result_ch.frame_length    = res_len;

`ifndef SYNTHESIS
  a_ok_matches_verdict: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_ok == (res_verdict == VERDICT_OK)))
    else $error("frame_ok disagrees with verdict");

  a_short_not_registration: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_verdict == VERDICT_TOO_SHORT) |-> (!res_reg && res_len < LEN_W'(2)))
    else $error("too short verdict with registration or length");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_eof) |=> (byte_count == '0 && crc == CRC_INIT))
    else $error("frame state not cleared after verdict");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_MAX)
    else $error("byte count above limit");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |-> (s1_eof && res_valid && !result_ch.ready))
    else $error("input register stalled without a blocked verdict");
`endif

endmodule
